// ===== rtl/mtks_pkg.sv =====
// ----------------------------------------------------------------------------
// mtks_pkg
// Shared types and constants for the MT19937 keystream byte mask block.
// ----------------------------------------------------------------------------
`default_nettype none

package mtks_pkg;

  // generator geometry
  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned WRAP_POINT   = STATE_WORDS - TWIST_OFFSET;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned ADDR_W       = $clog2(STATE_WORDS);
  localparam int unsigned IDX_W        = $clog2(STATE_WORDS + 1);
  localparam int unsigned BYTE_W       = 8;

  // generator constants
  localparam logic [WORD_W-1:0] SEED_RESET = 32'hF92F_EDB5;
  localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] HIGH_BIT   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS   = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] INIT_MULT  = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hEFC6_0000;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_INIT,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_TW_PRE,
    ST_TW_FIRST,
    ST_TW_RD,
    ST_TW_WR,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic seed_init;
    logic seed_mul;
    logic seed_add;
    logic tw_pre;
    logic tw_first;
    logic tw_rd;
    logic tw_wr;
    logic draw_rd;
    logic draw_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic seeded;
    logic idx_full;
    logic step_last;
    logic out_free;
  } status_t;

  // output tempering of one state word
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mtks_ram.sv =====
// ----------------------------------------------------------------------------
// mtks_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtks_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re0,
  input  wire logic [AW-1:0]    raddr0,
  output logic      [WIDTH-1:0] rdata0,
  input  wire logic             re1,
  input  wire logic [AW-1:0]    raddr1,
  output logic      [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata0_r;
  logic [WIDTH-1:0] rdata1_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read ports, data holds while not enabled
  always_ff @(posedge clk) begin
    if (re0) begin
      rdata0_r <= mem_r[raddr0];
    end
    if (re1) begin
      rdata1_r <= mem_r[raddr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

`default_nettype wire

// ===== rtl/mtks_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtks_ctrl
// Sequencer for reseed walk, twist pass and per-item draw.
// ----------------------------------------------------------------------------
`default_nettype none

module mtks_ctrl
  import mtks_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_first_of_message,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_first_of_message || !status.seeded) begin
            state_nxt = ST_SEED_INIT;
          end else if (status.idx_full) begin
            state_nxt = ST_TW_PRE;
          end else begin
            state_nxt = ST_DRAW_RD;
          end
        end
      end
      ST_SEED_INIT: state_nxt = ST_SEED_MUL;
      ST_SEED_MUL:  state_nxt = ST_SEED_ADD;
      ST_SEED_ADD: begin
        state_nxt = status.step_last ? ST_TW_PRE : ST_SEED_MUL;
      end
      ST_TW_PRE:    state_nxt = ST_TW_FIRST;
      ST_TW_FIRST:  state_nxt = ST_TW_WR;
      ST_TW_RD:     state_nxt = ST_TW_WR;
      ST_TW_WR: begin
        state_nxt = status.step_last ? ST_DRAW_RD : ST_TW_RD;
      end
      ST_DRAW_RD:   state_nxt = ST_DRAW_OUT;
      ST_DRAW_OUT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_SEED_INIT: cmd.seed_init = 1'b1;
      ST_SEED_MUL:  cmd.seed_mul  = 1'b1;
      ST_SEED_ADD:  cmd.seed_add  = 1'b1;
      ST_TW_PRE:    cmd.tw_pre    = 1'b1;
      ST_TW_FIRST:  cmd.tw_first  = 1'b1;
      ST_TW_RD:     cmd.tw_rd     = 1'b1;
      ST_TW_WR:     cmd.tw_wr     = 1'b1;
      ST_DRAW_RD:   cmd.draw_rd   = 1'b1;
      ST_DRAW_OUT:  cmd.draw_out  = status.out_free;
      default:      cmd           = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mtks_dp.sv =====
// ----------------------------------------------------------------------------
// mtks_dp
// Datapath: seed register, state store, seeding multiplier, twist mixer,
// tempering and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtks_dp
  import mtks_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [WORD_W-1:0] cfg_wr_data,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_last_of_message,
  input  wire cmd_t              cmd,
  output status_t                status,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [BYTE_W-1:0] out_masked_byte,
  output logic                   out_last_out
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] WRAP_ADDR = ADDR_W'(WRAP_POINT);
  localparam logic [ADDR_W-1:0] OFF_ADDR  = ADDR_W'(TWIST_OFFSET);
  localparam logic [IDX_W-1:0]  IDX_FULL  = IDX_W'(STATE_WORDS);

  logic [WORD_W-1:0] seed_r;
  logic              seeded_r;
  logic [IDX_W-1:0]  idx_r;
  logic [ADDR_W-1:0] step_r;
  logic [WORD_W-1:0] prev_r;
  logic [WORD_W-1:0] prod_r;
  logic [WORD_W-1:0] cur_r;
  logic [BYTE_W-1:0] data_r;
  logic              last_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic [WORD_W-1:0] prod_nxt;
  logic [WORD_W-1:0] seed_word;
  logic [WORD_W-1:0] mix_v;
  logic [WORD_W-1:0] twist_word;
  logic [WORD_W-1:0] tempered;
  logic [ADDR_W-1:0] nxt_addr;
  logic [ADDR_W-1:0] far_addr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re0;
  logic [ADDR_W-1:0] ram_raddr0;
  logic [WORD_W-1:0] ram_rdata0;
  logic              ram_re1;
  logic [ADDR_W-1:0] ram_raddr1;
  logic [WORD_W-1:0] ram_rdata1;

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  // seeding recurrence, multiply then add the step number
  assign prod_nxt  = INIT_MULT * (prev_r ^ (prev_r >> 30));
  assign seed_word = prod_r + WORD_W'(step_r);

  // twist mixer, cur_r holds the old value of the word being replaced
  assign mix_v      = (cur_r & HIGH_BIT) | (ram_rdata0 & LOW_BITS);
  assign twist_word = ram_rdata1 ^ (mix_v >> 1) ^ (mix_v[0] ? TWIST_XOR : '0);

  // neighbor and far addresses of the twist step
  assign nxt_addr = (step_r == LAST_ADDR) ? '0 : step_r + 1'b1;
  assign far_addr = (step_r < WRAP_ADDR) ? step_r + OFF_ADDR : step_r - WRAP_ADDR;

  // store port control
  assign ram_we     = cmd.seed_init | cmd.seed_add | cmd.tw_wr;
  assign ram_waddr  = cmd.seed_init ? '0 : step_r;
  assign ram_wdata  = cmd.seed_init ? seed_r : (cmd.seed_add ? seed_word : twist_word);
  assign ram_re0    = cmd.tw_pre | cmd.tw_first | cmd.tw_rd | cmd.draw_rd;
  assign ram_raddr0 = cmd.tw_pre ? '0 : (cmd.draw_rd ? idx_r[ADDR_W-1:0] : nxt_addr);
  assign ram_re1    = cmd.tw_first | cmd.tw_rd;
  assign ram_raddr1 = far_addr;

  mtks_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_WORDS),
    .AW    (ADDR_W)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re0    (ram_re0),
    .raddr0 (ram_raddr0),
    .rdata0 (ram_rdata0),
    .re1    (ram_re1),
    .raddr1 (ram_raddr1),
    .rdata1 (ram_rdata1)
  );

  // working registers of the seed walk and twist pass
  always_ff @(posedge clk) begin
    if (cmd.seed_init) begin
      prev_r <= seed_r;
      step_r <= ADDR_W'(1);
    end
    if (cmd.seed_mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.seed_add) begin
      prev_r <= seed_word;
      step_r <= step_r + 1'b1;
    end
    if (cmd.tw_pre) begin
      step_r <= '0;
    end
    if (cmd.tw_first) begin
      cur_r <= ram_rdata0;
    end
    if (cmd.tw_wr) begin
      cur_r  <= ram_rdata0;
      step_r <= step_r + 1'b1;
    end
  end

  // generator position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r <= 1'b0;
      idx_r    <= IDX_FULL;
    end else begin
      if (cmd.seed_init) begin
        seeded_r <= 1'b1;
        idx_r    <= IDX_FULL;
      end
      if (cmd.tw_wr && status.step_last) begin
        idx_r <= '0;
      end
      if (cmd.draw_out) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      data_r <= in_data_byte;
      last_r <= in_last_of_message;
    end
  end

  // result register
  assign tempered = temper(ram_rdata0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.draw_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_out) begin
      out_byte_r <= data_r ^ tempered[11:4];
      out_last_r <= last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_masked_byte = out_byte_r;
  assign out_last_out    = out_last_r;

  // status to the controller
  assign status.seeded    = seeded_r;
  assign status.idx_full  = (idx_r == IDX_FULL);
  assign status.step_last = (step_r == LAST_ADDR);
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ===== rtl/mt19937_keystream_byte_mask.sv =====
// ----------------------------------------------------------------------------
// mt19937_keystream_byte_mask
// XORs each byte with bits 11..4 of the next tempered MT19937 word.
// ----------------------------------------------------------------------------
// Each item steps through accept, a registered read of the single state store and
//   output; no new item is accepted until the last result is in the output register.
// A twist pass is due every 624th item (one lead-in read, then a read and a write
//   per word); a first-of-message item, or any item while unseeded, adds a seed
//   walk (multiply, then add and write) before that twist.
// Reset (rst_n low, synchronous): seed reloads its default, generator marked
//   unseeded, no result pending; the state store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module mt19937_keystream_byte_mask
  import mtks_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [WORD_W-1:0] cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_first_of_message,
  input  wire logic              in_last_of_message,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [BYTE_W-1:0] out_masked_byte,
  output logic                   out_last_out
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  mtks_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_first_of_message (in_first_of_message),
    .in_ready            (in_ready),
    .status              (status),
    .cmd                 (cmd)
  );

  // datapath
  mtks_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_data_byte       (in_data_byte),
    .in_last_of_message (in_last_of_message),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_masked_byte    (out_masked_byte),
    .out_last_out       (out_last_out)
  );

  // first-of-message item always starts a seed walk
  a_first_reseeds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_first_of_message |=> cmd.seed_init)
    else $error("first item did not start a reseed");

  // no draw from an unseeded store
  a_no_draw_unseeded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw_rd |-> status.seeded)
    else $error("draw while unseeded");

  // end of twist pass goes straight to a draw
  a_twist_then_draw: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tw_wr && status.step_last |=> cmd.draw_rd)
    else $error("twist end not followed by draw");

  // a finished draw shows a result next cycle
  a_draw_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw_out |=> out_valid)
    else $error("result not presented after draw");

endmodule

`default_nettype wire
